>>> design/cif_pkg.sv
// shared types and constants of the cursor image formatter
package cif_pkg;

	localparam int CFG_DATA_W = 24;
	localparam int CFG_INDEX_W = 3;
	localparam int COL_W = 6;

	localparam logic [CFG_INDEX_W-1:0] REG_CURSOR_FORMAT = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FG_COLOR_RGB = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_BG_COLOR_RGB = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_ARGB_WIDTH = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_MSB_FIRST = 3'd4;

	localparam logic [6:0] ARGB_WIDTH_RESET = 7'd64;
	localparam logic [4:0] MONO_LAST_IDX = 5'd31;

	typedef struct packed {
		logic        cursor_format;
		logic [23:0] fg_color_rgb;
		logic [23:0] bg_color_rgb;
		logic [6:0]  argb_width;
		logic        msb_first;
	} cfg_t;

	typedef struct packed {
		logic        mode;
		logic [31:0] source_word;
		logic [31:0] mask_word;
	} in_item_t;

	typedef struct packed {
		logic [31:0] pixel;
		logic        last;
	} out_item_t;

	// one unit of work for the back end
	typedef struct packed {
		logic             argb;
		logic [31:0]      img;
		logic [31:0]      mask;
		logic [31:0]      fg;
		logic [31:0]      bg;
		logic [COL_W-1:0] pad;
	} job_t;

endpackage

>>> design/cif_fifo.sv
// small register queue used between front and back and on the result side
module cif_fifo
	import cif_pkg::*;
#(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({wr, rd})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) wr |-> !full)
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) rd |-> !empty)
		else $error("queue read while empty");

endmodule

>>> design/cif_front.sv
// front end: takes items, converts colours, premultiplies argb and plans row padding
module cif_front
	import cif_pkg::*;
#(
	parameter int ROW_PITCH = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  in_item_t item,
	output logic     full,
	input  cfg_t     cfg,
	input  logic     job_full,
	output logic     job_wr,
	output job_t     job
);

	localparam logic [6:0] PITCH = 7'(ROW_PITCH);

	function automatic logic [31:0] colour_conv(input logic fmt, input logic [23:0] c);
		logic [31:0] res;
		if (fmt) begin
			res = {8'hff, c};
		end else begin
			res = {16'h0000, 1'b1, c[23:19], c[15:11], c[7:3]};
		end
		return res;
	endfunction

	// exact floor(x / 255) for any 16-bit x up to 65279
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] s;
		s = 17'(x) + 17'(x[15:8]) + 17'd1;
		return s[15:8];
	endfunction

	logic             accept;
	logic             s1_valid_q;
	logic             argb_s1;
	logic             msb_s1;
	logic [31:0]      src_s1;
	logic [31:0]      mask_s1;
	logic [31:0]      fg_s1;
	logic [31:0]      bg_s1;
	logic [COL_W-1:0] pad_s1;
	logic [15:0]      prod_r_s1;
	logic [15:0]      prod_g_s1;
	logic [15:0]      prod_b_s1;
	logic [COL_W-1:0] col_q;

	logic [6:0]       w_eff;
	logic [6:0]       col_inc;
	logic             row_end;
	logic [31:0]      premul_px;
	logic [31:0]      argb_px;

	assign full = s1_valid_q && job_full;
	assign accept = push && !full;
	assign job_wr = s1_valid_q && !job_full;

	// effective row width, column bookkeeping
	always_comb begin
		if (cfg.argb_width == 7'd0) begin
			w_eff = 7'd1;
		end else if (cfg.argb_width > PITCH) begin
			w_eff = PITCH;
		end else begin
			w_eff = cfg.argb_width;
		end
		col_inc = 7'(col_q) + 7'd1;
		row_end = (col_inc >= w_eff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			col_q <= '0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (job_wr) begin
				s1_valid_q <= 1'b0;
			end
			if (accept && item.mode) begin
				col_q <= row_end ? '0 : col_inc[COL_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			argb_s1 <= item.mode;
			msb_s1 <= cfg.msb_first;
			fg_s1 <= colour_conv(cfg.cursor_format, cfg.fg_color_rgb);
			bg_s1 <= colour_conv(cfg.cursor_format, cfg.bg_color_rgb);
			// mono words are reversed here so the back end always takes bit 0
			if (!item.mode && cfg.msb_first) begin
				src_s1 <= {<<{item.source_word}};
				mask_s1 <= {<<{item.mask_word}};
			end else begin
				src_s1 <= item.source_word;
				mask_s1 <= item.mask_word;
			end
			pad_s1 <= (item.mode && row_end) ? COL_W'(PITCH - col_inc) : '0;
			prod_r_s1 <= 16'(item.source_word[23:16]) * 16'(item.source_word[31:24]);
			prod_g_s1 <= 16'(item.source_word[15:8]) * 16'(item.source_word[31:24]);
			prod_b_s1 <= 16'(item.source_word[7:0]) * 16'(item.source_word[31:24]);
		end
	end

	always_comb begin
		if (src_s1[31:24] == 8'hff) begin
			premul_px = src_s1;
		end else begin
			premul_px = {src_s1[31:24], div255(prod_r_s1), div255(prod_g_s1),
				div255(prod_b_s1)};
		end
		argb_px = msb_s1 ? {<<8{premul_px}} : premul_px;

		job.argb = argb_s1;
		job.img = src_s1;
		job.mask = mask_s1;
		job.fg = argb_s1 ? argb_px : fg_s1;
		job.bg = bg_s1;
		job.pad = pad_s1;
	end

	a_row_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.mode && row_end) |=> (col_q == '0))
		else $error("column not cleared at row end");

endmodule

>>> design/cif_back.sv
// back end: expands one job into its pixel sequence, one pixel a cycle unless the result queue is full
module cif_back
	import cif_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      job_empty,
	input  job_t      job,
	output logic      job_rd,
	input  logic      res_full,
	output logic      res_wr,
	output out_item_t res
);

	logic             active_q;
	logic             argb_q;
	logic             first_q;
	logic [31:0]      img_q;
	logic [31:0]      mask_q;
	logic [31:0]      fg_q;
	logic [31:0]      bg_q;
	logic [4:0]       idx_q;
	logic [COL_W-1:0] pad_q;
	logic             done;

	assign res_wr = active_q && !res_full;
	assign done = res_wr && res.last;
	assign job_rd = !job_empty && (!active_q || done);

	always_comb begin
		if (argb_q) begin
			res.pixel = first_q ? fg_q : 32'h0;
			res.last = (pad_q == '0);
		end else begin
			res.pixel = mask_q[0] ? (img_q[0] ? fg_q : bg_q) : 32'h0;
			res.last = (idx_q == MONO_LAST_IDX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (job_rd) begin
			active_q <= 1'b1;
		end else if (done) begin
			active_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (job_rd) begin
			argb_q <= job.argb;
			first_q <= 1'b1;
			img_q <= job.img;
			mask_q <= job.mask;
			fg_q <= job.fg;
			bg_q <= job.bg;
			idx_q <= '0;
			pad_q <= job.pad;
		end else if (res_wr) begin
			first_q <= 1'b0;
			img_q <= {1'b0, img_q[31:1]};
			mask_q <= {1'b0, mask_q[31:1]};
			idx_q <= idx_q + 5'd1;
			if (argb_q) begin
				pad_q <= pad_q - 1'b1;
			end
		end
	end

	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !job_rd) |=> !active_q)
		else $error("back end still busy after final pixel");

endmodule

>>> design/cursor_image_formatter_top.sv
// top level of the cursor image formatter: registers, front, job queue, back, result queue
//
//  channel   | ports                          | transaction
//  ----------+--------------------------------+-------------------------------------
//  items     | push, full, item               | push && !full at a rising edge
//  results   | pop, empty, result             | pop && !empty at a rising edge
//  registers | cfg_write, cfg_index, cfg_data | cfg_write at a rising edge
//
//  one result is made per cycle while the result queue has room: a mono item gives
//  32 results, an argb pixel one, or ROW_PITCH - column results when it closes a row;
//  the single result port sets this rate; on an idle block the first result passes the
//  front stage, the job queue, the back end registers and the result queue to the ports
//  the front end keeps taking items while the back end works, until the job queue fills
//  arst_n resets queues, column and registers at once; no clearing pass
module cursor_image_formatter_top
	import cif_pkg::*;
#(
	parameter int ROW_PITCH = 64,
	parameter int JOB_DEPTH = 2,
	parameter int RES_DEPTH = 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// item side
	input  logic                   push,
	output logic                   full,
	input  in_item_t               item,
	// result side
	input  logic                   pop,
	output logic                   empty,
	output out_item_t              result,
	// register writes
	input  logic                   cfg_write,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_t      cfg_q;
	logic      job_wr;
	logic      job_full;
	logic      job_rd;
	logic      job_empty;
	job_t      job_in;
	job_t      job_out;
	logic      res_wr;
	logic      res_full;
	out_item_t res_in;

	// register file; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cursor_format <= 1'b0;
			cfg_q.fg_color_rgb <= '0;
			cfg_q.bg_color_rgb <= '0;
			cfg_q.argb_width <= ARGB_WIDTH_RESET;
			cfg_q.msb_first <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_CURSOR_FORMAT: cfg_q.cursor_format <= cfg_data[0];
				REG_FG_COLOR_RGB: cfg_q.fg_color_rgb <= cfg_data[23:0];
				REG_BG_COLOR_RGB: cfg_q.bg_color_rgb <= cfg_data[23:0];
				REG_ARGB_WIDTH: cfg_q.argb_width <= cfg_data[6:0];
				REG_MSB_FIRST: cfg_q.msb_first <= cfg_data[0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	// front: classify, colour conversion, premultiply, row padding plan
	cif_front #(
		.ROW_PITCH(ROW_PITCH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.item(item),
		.full(full),
		.cfg(cfg_q),
		.job_full(job_full),
		.job_wr(job_wr),
		.job(job_in)
	);

	// short job queue decouples the two halves
	cif_fifo #(
		.WIDTH($bits(job_t)),
		.DEPTH(JOB_DEPTH)
	) u_job_q (
		.clk(clk),
		.arst_n(arst_n),
		.wr(job_wr),
		.wr_data(job_in),
		.full(job_full),
		.rd(job_rd),
		.rd_data(job_out),
		.empty(job_empty)
	);

	// back: pixel sequencer
	cif_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.job_empty(job_empty),
		.job(job_out),
		.job_rd(job_rd),
		.res_full(res_full),
		.res_wr(res_wr),
		.res(res_in)
	);

	// result queue, so a stalled consumer holds up the sequencer only once the queue is full
	cif_fifo #(
		.WIDTH($bits(out_item_t)),
		.DEPTH(RES_DEPTH)
	) u_res_q (
		.clk(clk),
		.arst_n(arst_n),
		.wr(res_wr),
		.wr_data(res_in),
		.full(res_full),
		.rd(pop && !empty),
		.rd_data(result),
		.empty(empty)
	);

endmodule
